// ===== sv/npcl_pkg.sv =====
// Shared types, constants and helper functions of the nearest palette color lookup.
`default_nettype none

package npcl_pkg;

	// Request kinds carried in the input tuser bit.
	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_LOOKUP = 1'b1;

	// Field widths.
	localparam int SIZE_W  = 9;
	localparam int IDX_W   = 8;
	localparam int CHAN_W  = 16;
	localparam int Q_W     = 5;
	localparam int DIST_W  = 18;
	localparam int ENTRY_W = 3 * CHAN_W;
	localparam int SLOT_W  = 13;

	// Largest number of entries one lookup can scan (index space of the result).
	localparam int IDX_SPACE = 256;

	// Initial best distance, above any real distance of 3 * 65535.
	localparam logic [DIST_W-1:0] START_BOUND = 18'd196608;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic wr;
		logic issue;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic empty;
		logic last_issue;
		logic pipe_busy;
		logic out_free;
	} sts_t;

	// Widen a 5-bit channel to 8 bits by bit replication, then move it to the top byte.
	function automatic logic [CHAN_W-1:0] widen5(input logic [Q_W-1:0] c);
		return {c, c[4:2], 8'h00};
	endfunction

endpackage

`default_nettype wire

// ===== sv/nearest_palette_color_lookup.sv =====
// Top level of the nearest palette color lookup: controller plus datapath.
//
//   Channel   Direction  Handshake             Payload
//   s_*       in         s_tvalid / s_tready   tuser = req_type, tdata = entry and query fields
//   m_*       out        m_tvalid / m_tready   tuser = match_found, tdata = index and distance
//   cfg_*     in         cfg_valid / cfg_ready cfg_data = palette_size
//
// A palette write request is accepted in idle and the block stays idle. A lookup
// request scans n entries, n being the search length (palette_size, at most 256):
// the single read port of the palette memory delivers one entry per cycle.
// Reset clears the controller, the palette_size register and the result
// valid; the palette memory is not cleared. A result waiting on m_tready
// does not block new requests until the next lookup finishes its scan.
`default_nettype none

module nearest_palette_color_lookup #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	// [7:0] entry_index, [23:8] entry_red, [39:24] entry_green, [55:40] entry_blue,
	// [60:56] query_red, [65:61] query_green, [70:66] query_blue, [71] zero
	input  wire logic [71:0] s_tdata,
	// [0] req_type
	input  wire logic        s_tuser,
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	// [7:0] match_index, [25:8] match_distance, [31:26] zero
	output      logic [31:0] m_tdata,
	// [0] match_found
	output      logic        m_tuser,
	input  wire logic        cfg_valid,
	output      logic        cfg_ready,
	input  wire logic [8:0]  cfg_data
);

	import npcl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	npcl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.req_type (s_tuser),
		.sts      (sts),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	npcl_dp #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ===== sv/npcl_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module npcl_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/npcl_ctrl.sv =====
// Controller state machine that sequences palette writes and lookup scans.
`default_nettype none

module npcl_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          req_type,
	input  wire npcl_pkg::sts_t sts,
	output      logic          s_tready,
	output      npcl_pkg::cmd_t cmd
);

	import npcl_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d      = state_q;
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.wr       = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (req_type == REQ_LOOKUP) begin
						cmd.start = 1'b1;
						state_d   = sts.empty ? ST_DONE : ST_SCAN;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
				if (sts.last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A scan never starts while the block is busy with another request.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> (state_q == ST_IDLE))
		else $error("scan started outside idle");

	// The result is loaded only after the scan pipeline has emptied.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.pipe_busy)
		else $error("result loaded while the scan pipeline is busy");

	// A lookup on an empty palette goes straight to the result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start && sts.empty) |=> (state_q == ST_DONE))
		else $error("empty palette lookup did not skip the scan");

endmodule

`default_nettype wire

// ===== sv/npcl_dp.sv =====
// Datapath: palette memory, scan counter, distance pipeline, best-match tracking and result register.
`default_nettype none

module npcl_dp #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [71:0]                  s_tdata,
	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [npcl_pkg::SIZE_W-1:0]  cfg_data,
	output      logic                         m_tvalid,
	input  wire logic                         m_tready,
	output      logic [31:0]                  m_tdata,
	output      logic                         m_tuser,
	input  wire npcl_pkg::cmd_t               cmd,
	output      npcl_pkg::sts_t               sts
);

	import npcl_pkg::*;

	localparam int AW    = $clog2(PALETTE_DEPTH);
	localparam int LIMIT = (PALETTE_DEPTH < IDX_SPACE) ? PALETTE_DEPTH : IDX_SPACE;

	// Unpacked request fields.
	logic [IDX_W-1:0]  in_index;
	logic [CHAN_W-1:0] in_red;
	logic [CHAN_W-1:0] in_green;
	logic [CHAN_W-1:0] in_blue;
	logic [Q_W-1:0]    in_qr;
	logic [Q_W-1:0]    in_qg;
	logic [Q_W-1:0]    in_qb;

	assign in_index = s_tdata[7:0];
	assign in_red   = s_tdata[23:8];
	assign in_green = s_tdata[39:24];
	assign in_blue  = s_tdata[55:40];
	assign in_qr    = s_tdata[60:56];
	assign in_qg    = s_tdata[65:61];
	assign in_qb    = s_tdata[70:66];

	logic [SIZE_W-1:0]  size_q;
	logic [SIZE_W-1:0]  n_q;
	logic [SIZE_W-1:0]  cnt_q;
	logic [CHAN_W-1:0]  qr_q;
	logic [CHAN_W-1:0]  qg_q;
	logic [CHAN_W-1:0]  qb_q;
	logic               v_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               v_s2;
	logic [IDX_W-1:0]   idx_s2;
	logic [DIST_W-1:0]  dist_s2;
	logic               found_q;
	logic [IDX_W-1:0]   best_i_q;
	logic [DIST_W-1:0]  best_d_q;
	logic               out_valid_q;
	logic               out_found_q;
	logic [IDX_W-1:0]   out_index_q;
	logic [DIST_W-1:0]  out_dist_q;
	logic [SIZE_W-1:0]  n_eff;
	logic               wr_ok;
	logic [ENTRY_W-1:0] rd_data;
	logic [DIST_W-1:0]  dist_sum;

	function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
	                                              input logic [CHAN_W-1:0] b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// Configuration register; the user must write it only while idle, the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_valid) begin
			size_q <= cfg_data;
		end
	end

	// Search length saturates at the smaller of the memory depth and the index space.
	assign n_eff = (size_q > SIZE_W'(LIMIT)) ? SIZE_W'(LIMIT) : size_q;

	// Writes to slots beyond the memory are dropped.
	assign wr_ok = cmd.wr && ({{(SLOT_W-IDX_W){1'b0}}, in_index} < SLOT_W'(PALETTE_DEPTH));

	npcl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PALETTE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_ok),
		.wr_addr (AW'(in_index)),
		.wr_data ({in_blue, in_green, in_red}),
		.rd_en   (cmd.issue),
		.rd_addr (AW'(cnt_q[IDX_W-1:0])),
		.rd_data (rd_data)
	);

	// Lookup setup and scan address counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			n_q   <= '0;
		end else if (cmd.start) begin
			cnt_q <= '0;
			n_q   <= n_eff;
		end else if (cmd.issue) begin
			cnt_q <= cnt_q + SIZE_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qr_q <= widen5(in_qr);
			qg_q <= widen5(in_qg);
			qb_q <= widen5(in_qb);
		end
	end

	// Stage valids: memory read, then distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// Sum of absolute channel differences against the entry just read.
	assign dist_sum = DIST_W'(absdiff(qr_q, rd_data[15:0]))
	                + DIST_W'(absdiff(qg_q, rd_data[31:16]))
	                + DIST_W'(absdiff(qb_q, rd_data[47:32]));

	always_ff @(posedge clk) begin
		idx_s1  <= cnt_q[IDX_W-1:0];
		idx_s2  <= idx_s1;
		dist_s2 <= dist_sum;
	end

	// Keep the first entry with the smallest distance.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			best_i_q <= '0;
			best_d_q <= START_BOUND;
		end else if (cmd.start) begin
			found_q  <= 1'b0;
			best_i_q <= '0;
			best_d_q <= START_BOUND;
		end else if (v_s2 && (dist_s2 < best_d_q)) begin
			found_q  <= 1'b1;
			best_i_q <= idx_s2;
			best_d_q <= dist_s2;
		end
	end

	// Result register; holds the result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_found_q <= found_q;
			out_index_q <= found_q ? best_i_q : '0;
			out_dist_q  <= found_q ? best_d_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_found_q;
	assign m_tdata  = {6'b0, out_dist_q, out_index_q};

	// Status to the controller.
	assign sts.empty      = (size_q == '0);
	assign sts.last_issue = ((cnt_q + SIZE_W'(1)) == n_q);
	assign sts.pipe_busy  = v_s1 || v_s2;
	assign sts.out_free   = !out_valid_q || m_tready;

	// The scan never reads past the search length.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (cnt_q < n_q))
		else $error("scan read beyond the search length");

	// A result is never loaded over one the sink has not taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || m_tready))
		else $error("result register overwritten");

	// A no-match result carries a zero index and distance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> ((out_dist_q == '0) && (out_index_q == '0)))
		else $error("no-match result is not zero");

endmodule

`default_nettype wire

// ===== dv/nearest_palette_color_lookup_test.sv =====
// Self-checking testbench for the nearest palette color lookup, with its scoreboard class.
`default_nettype none

import npcl_pkg::REQ_WRITE;
import npcl_pkg::REQ_LOOKUP;
import npcl_pkg::SIZE_W;
import npcl_pkg::IDX_W;
import npcl_pkg::CHAN_W;
import npcl_pkg::Q_W;
import npcl_pkg::DIST_W;

typedef struct packed {
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;
} rgb16_t;

typedef struct packed {
	logic [IDX_W-1:0]  index;
	logic              found;
	logic [DIST_W-1:0] distance;
} palette_match_t;

typedef struct {
	logic             req_type;
	logic [IDX_W-1:0] entry_index;
	rgb16_t           entry;
	logic [Q_W-1:0]   query_red;
	logic [Q_W-1:0]   query_green;
	logic [Q_W-1:0]   query_blue;
} palette_request_t;

// Shadow palette, nearest-color predictor and queue of expected lookup results.
class nearest_color_scoreboard;
	rgb16_t            palette_copy [256];
	logic [SIZE_W-1:0] search_size;
	palette_match_t    expected_matches [$];
	int unsigned       lookups_checked;
	int                errors;

	function new();
		foreach (palette_copy[i])
			palette_copy[i] = '0;
		search_size = '0;
		lookups_checked = 0;
		errors = 0;
	endfunction

	function void set_search_size(logic [SIZE_W-1:0] value);
		search_size = value;
	endfunction

	function int pending();
		return expected_matches.size();
	endfunction

	// Every mismatch is counted and printed on one line.
	task report(string what);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// A 5-bit channel is replicated up to 8 bits and placed in the top byte.
	function int unsigned widen_channel(logic [Q_W-1:0] c);
		int unsigned c8;
		c8 = ((int'(c) << 3) | (int'(c) >> 2)) & 255;
		return c8 << 8;
	endfunction

	function int unsigned channel_gap(int unsigned a, int unsigned b);
		return (a >= b) ? (a - b) : (b - a);
	endfunction

	// Manhattan search over the active part of the palette; the lowest index wins ties.
	function palette_match_t nearest_entry(palette_request_t req);
		palette_match_t best;
		int unsigned    span, wr, wg, wb, d, best_d;
		span = (search_size > 256) ? 256 : search_size;
		wr = widen_channel(req.query_red);
		wg = widen_channel(req.query_green);
		wb = widen_channel(req.query_blue);
		best = '0;
		best_d = 3 * 65536;
		for (int i = 0; i < span; i++) begin
			d = channel_gap(wr, palette_copy[i].red) + channel_gap(wg, palette_copy[i].green)
				+ channel_gap(wb, palette_copy[i].blue);
			if (d < best_d) begin
				best_d = d;
				best.index = i[IDX_W-1:0];
				best.found = 1'b1;
				best.distance = d[DIST_W-1:0];
			end
		end
		return best;
	endfunction

	// Called for each accepted request, in acceptance order.
	function void note_request(palette_request_t req);
		if (req.req_type == REQ_WRITE)
			palette_copy[req.entry_index] = req.entry;
		else
			expected_matches.push_back(nearest_entry(req));
	endfunction

	task check_match(palette_match_t got);
		palette_match_t want;
		if (expected_matches.size() == 0) begin
			report($sformatf("result with no lookup pending (index %0d)", got.index));
		end else begin
			want = expected_matches.pop_front();
			if (got.index !== want.index)
				report($sformatf("lookup %0d: match_index %0d, expected %0d",
					lookups_checked, got.index, want.index));
			if (got.found !== want.found)
				report($sformatf("lookup %0d: match_found %0b, expected %0b",
					lookups_checked, got.found, want.found));
			if (got.distance !== want.distance)
				report($sformatf("lookup %0d: match_distance %0d, expected %0d",
					lookups_checked, got.distance, want.distance));
		end
		lookups_checked++;
	endtask
endclass

module nearest_palette_color_lookup_test;

	localparam int DEPTH          = 256;
	localparam int TOTAL_REQUESTS = 1750;
	localparam int SETTLE_CYCLES  = 8;
	localparam int DRAIN_CYCLES   = 16;
	localparam int WATCHDOG_LIMIT = 4000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [8:0]  cfg_data;

	// When set, neither side inserts gaps or stalls.
	logic        quiet;
	int          requests_sent;

	nearest_color_scoreboard sb = new();

	nearest_palette_color_lookup #(
		.PALETTE_DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Pause lengths: mostly short, a few long.
	function int pick_pause();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function int pick_gap();
		if (quiet || $urandom_range(99) < 55)
			return 0;
		return pick_pause();
	endfunction

	// Palette channel values lean toward the ends of the range and toward query colors.
	function logic [CHAN_W-1:0] random_channel();
		logic [Q_W-1:0] c;
		c = Q_W'($urandom_range(31));
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return {c, c[4:2], 8'h00};
			4: return CHAN_W'({c, c[4:2], 8'h00} + $urandom_range(0, 3));
			default: return CHAN_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function palette_request_t make_write(logic [IDX_W-1:0] slot, rgb16_t color);
		palette_request_t req;
		req.req_type = REQ_WRITE;
		req.entry_index = slot;
		req.entry = color;
		req.query_red = Q_W'($urandom_range(31));
		req.query_green = Q_W'($urandom_range(31));
		req.query_blue = Q_W'($urandom_range(31));
		return req;
	endfunction

	function palette_request_t make_lookup(logic [Q_W-1:0] qr, logic [Q_W-1:0] qg,
			logic [Q_W-1:0] qb);
		palette_request_t req;
		req.req_type = REQ_LOOKUP;
		req.entry_index = IDX_W'($urandom_range(255));
		req.entry = {16'($urandom), 16'($urandom), 16'($urandom)};
		req.query_red = qr;
		req.query_green = qg;
		req.query_blue = qb;
		return req;
	endfunction

	// A write now and then copies another slot, so that equal distances occur.
	function palette_request_t random_write(logic [IDX_W-1:0] slot);
		rgb16_t color;
		if ($urandom_range(9) == 0)
			color = sb.palette_copy[$urandom_range(DEPTH - 1)];
		else
			color = {random_channel(), random_channel(), random_channel()};
		return make_write(slot, color);
	endfunction

	function palette_request_t random_request();
		if ($urandom_range(3) == 0)
			return random_write(IDX_W'($urandom_range(DEPTH - 1)));
		return make_lookup(Q_W'($urandom_range(31)), Q_W'($urandom_range(31)),
			Q_W'($urandom_range(31)));
	endfunction

	// Mostly short searches, some long ones, and a few oversized settings.
	function logic [SIZE_W-1:0] pick_search_size();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return '0;
		else if (r < 60)
			return SIZE_W'($urandom_range(1, 16));
		else if (r < 85)
			return SIZE_W'($urandom_range(17, 128));
		else if (r < 95)
			return SIZE_W'($urandom_range(129, 256));
		return SIZE_W'($urandom_range(257, 511));
	endfunction

	// Drive one request after a random gap and note it once it is accepted.
	task send_request(palette_request_t req);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = req.req_type;
		s_tdata = {1'b0, req.query_blue, req.query_green, req.query_red,
			req.entry.blue, req.entry.green, req.entry.red, req.entry_index};
		do @(posedge clk); while (!s_tready);
		sb.note_request(req);
		requests_sent++;
	endtask

	// Stop sending and wait until every expected result is in and the block has settled.
	task wait_until_idle(int settle);
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task set_palette_size(logic [SIZE_W-1:0] value);
		wait_until_idle(SETTLE_CYCLES);
		cfg_valid = 1'b1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_search_size(value);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Result side: sample at the rising edge, change ready at the falling edge.
	initial begin : result_sink
		int hold;
		hold = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_match('{index: m_tdata[7:0], found: m_tuser,
					distance: m_tdata[25:8]});
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else if (quiet) begin
				m_tready = 1'b1;
				hold = $urandom_range(4, 30);
			end else if (m_tready) begin
				m_tready = 1'b0;
				hold = pick_pause() - 1;
			end else begin
				m_tready = 1'b1;
				hold = $urandom_range(0, 10);
			end
		end
	end

	// The run ends as failed if no channel moves anything for too long.
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
					|| (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int phase, batch;
		logic [SIZE_W-1:0] size_now;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = REQ_WRITE;
		cfg_valid = 1'b0;
		cfg_data = '0;
		quiet = 1'b0;
		requests_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty palette: lookups report no match.
		set_palette_size('0);
		send_request(make_lookup('0, '0, '0));
		send_request(make_lookup('1, '1, '1));
		send_request(make_write(8'd255, '1));
		send_request(make_write(8'd0, '0));
		send_request(make_write(8'd1, {16'hFFFF, 16'h0000, 16'h0000}));
		send_request(make_write(8'd2, '0));

		// Three entries, the third equal to the first: the lower index wins the tie.
		set_palette_size(9'd3);
		send_request(make_lookup('0, '0, '0));
		send_request(make_lookup('1, '0, '0));
		send_request(make_lookup('1, '1, '1));
		send_request(make_lookup(5'd16, 5'd8, 5'd1));
		send_request(make_write(8'd1, {16'h0000, 16'hFFFF, 16'h8421}));
		send_request(make_lookup('0, '1, 5'd16));

		// A single entry searched.
		set_palette_size(9'd1);
		send_request(make_lookup('1, '1, '1));
		send_request(make_lookup(5'd10, 5'd21, 5'd0));

		// Fill the whole palette so that every search length is allowed from here on.
		for (int slot = 0; slot < DEPTH; slot++)
			send_request(random_write(IDX_W'(slot)));

		// Phases of random traffic, each under its own search length.
		phase = 0;
		while (requests_sent < TOTAL_REQUESTS) begin
			case (phase)
				0: size_now = 9'd256;
				1: size_now = '1;
				2: size_now = '0;
				3: size_now = 9'd2;
				default: size_now = pick_search_size();
			endcase
			set_palette_size(size_now);
			quiet = ($urandom_range(3) == 0);
			batch = $urandom_range(10, 60);
			for (int k = 0; k < batch && requests_sent < TOTAL_REQUESTS; k++)
				send_request(random_request());
			quiet = 1'b0;
			phase++;
		end

		wait_until_idle(DRAIN_CYCLES);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

`default_nettype wire
